/* sv/m4cm_pkg.sv */
// ----------------------------------------------------------------------------
// m4cm_pkg
// Types and constants shared by the 4x4 column multiplier.
// ----------------------------------------------------------------------------
package m4cm_pkg;

	localparam int NUM_ROWS = 4;
	localparam int NUM_COLS = 4;
	localparam int COL_W    = 2;
	localparam int ELEM_W   = 32;
	localparam int PROD_W   = 2 * ELEM_W;
	// four products summed exactly need two more bits
	localparam int ACC_W    = PROD_W + 2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_MUL  = 1'b1;

	localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	typedef logic [COL_W-1:0] col_t;

	// one word as it travels down the chain of cells
	typedef struct packed {
		logic                           kind;
		col_t                           col;
		logic [NUM_ROWS-1:0][ELEM_W-1:0] b;
		logic [NUM_ROWS-1:0][ACC_W-1:0]  acc;
	} word_t;

endpackage

/* sv/m4cm_req_if.sv */
// ----------------------------------------------------------------------------
// m4cm_req_if
// Input channel: one column word, either a load of A or a multiply by A.
// ----------------------------------------------------------------------------
interface m4cm_req_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [1:0]         column_index;
	logic signed [31:0] elem0;
	logic signed [31:0] elem1;
	logic signed [31:0] elem2;
	logic signed [31:0] elem3;

	modport source (
		output valid, kind, column_index, elem0, elem1, elem2, elem3,
		input  ready
	);
	modport sink (
		input  valid, kind, column_index, elem0, elem1, elem2, elem3,
		output ready
	);
endinterface

/* sv/m4cm_rsp_if.sv */
// ----------------------------------------------------------------------------
// m4cm_rsp_if
// Output channel: one product column with its saturation flag.
// ----------------------------------------------------------------------------
interface m4cm_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         result_column;
	logic signed [31:0] res0;
	logic signed [31:0] res1;
	logic signed [31:0] res2;
	logic signed [31:0] res3;
	logic               saturated;

	modport source (
		output valid, result_column, res0, res1, res2, res3, saturated,
		input  ready
	);
	modport sink (
		input  valid, result_column, res0, res1, res2, res3, saturated,
		output ready
	);
endinterface

/* sv/matrix4_column_multiply.sv */
// ----------------------------------------------------------------------------
// matrix4_column_multiply
// Stored 4x4 fixed-point matrix A times streamed columns of B.
// ----------------------------------------------------------------------------
// Channels: req takes one column word per cycle if ready. kind 0 writes column
// column_index of A (column-major) from elem0..elem3 and gives no result;
// kind 1 treats elem0..elem3 as column column_index of B and later presents
// column column_index of A*B on rsp, with saturated set if any row clipped.
// Row sums are exact, floor-shifted by FRAC_BITS and clipped to 32 bits.
// Structure: four cells, one per column of A, each with a multiply stage
// and an accumulate stage, followed by a shift/saturate output register.
// Throughput: one word per cycle while rsp is not held.
// A load takes effect for every word accepted after it; words ahead of it
// still see the old column.
// Reset: A becomes the identity, the pipeline empties.
// Stall: while rsp is held, words keep entering until the stages fill; each
// stage stalls only when the one after it is full and not moving.
// ----------------------------------------------------------------------------
module matrix4_column_multiply #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	m4cm_req_if.sink    req,
	m4cm_rsp_if.source  rsp
);

	localparam int NumCells = m4cm_pkg::NUM_COLS;

	logic [NumCells:0]  chain_valid;
	logic [NumCells:0]  chain_ready;
	m4cm_pkg::word_t    chain_word [NumCells+1];

	// pack the incoming column; the row sums start at zero
	assign chain_valid[0]     = req.valid;
	assign req.ready          = chain_ready[0];
	assign chain_word[0].kind = req.kind;
	assign chain_word[0].col  = req.column_index;
	assign chain_word[0].b    = {req.elem3, req.elem2, req.elem1, req.elem0};
	assign chain_word[0].acc  = '0;

	// one cell per column of A
	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		m4cm_cell #(
			.CellIdx  (k),
			.FracBits (FRAC_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_word   (chain_word[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_word  (chain_word[k+1])
		);
	end

	m4cm_sat #(
		.FracBits (FRAC_BITS)
	) u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[NumCells]),
		.in_ready (chain_ready[NumCells]),
		.in_word  (chain_word[NumCells]),
		.rsp      (rsp)
	);

endmodule

/* sv/m4cm_cell.sv */
// ----------------------------------------------------------------------------
// m4cm_cell
// One column of A: takes a load for its column, otherwise multiplies its
// column by the matching element of B and adds into the running row sums.
// ----------------------------------------------------------------------------
module m4cm_cell #(
	parameter int CellIdx  = 0,
	parameter int FracBits = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  m4cm_pkg::word_t in_word,
	output logic            out_valid,
	input  logic            out_ready,
	output m4cm_pkg::word_t out_word
);

	localparam m4cm_pkg::col_t MyCol = m4cm_pkg::COL_W'(CellIdx);
	localparam logic [m4cm_pkg::ELEM_W-1:0] One =
		m4cm_pkg::ELEM_W'(64'(1) << FracBits);

	logic [m4cm_pkg::NUM_ROWS-1:0][m4cm_pkg::ELEM_W-1:0] col_q;

	logic                                 v_s1;
	m4cm_pkg::word_t                      w_s1;
	logic signed [m4cm_pkg::PROD_W-1:0]   prod_s1 [m4cm_pkg::NUM_ROWS];
	logic                                 v_s2;
	m4cm_pkg::word_t                      w_s2;

	logic s2_ready;
	logic in_fire;
	logic load_here;

	// stage handshake: a stage moves when it is empty or the next one moves
	assign s2_ready  = !v_s2 || out_ready;
	assign in_ready  = !v_s1 || s2_ready;
	assign in_fire   = in_valid && in_ready;
	assign load_here = (in_word.kind == m4cm_pkg::KIND_LOAD) && (in_word.col == MyCol);

	// hold this column of A; reset to the identity column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < m4cm_pkg::NUM_ROWS; r++) begin
				col_q[r] <= (r == CellIdx) ? One : '0;
			end
		end else if (in_fire && load_here) begin
			col_q <= in_word.b;
		end
	end

	// stage valids: drop the load that ends in this cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_fire && !load_here;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
		end
	end

	// multiply the stored column by this cell's element of B
	always_ff @(posedge clk) begin
		if (in_ready) begin
			w_s1 <= in_word;
			for (int r = 0; r < m4cm_pkg::NUM_ROWS; r++) begin
				prod_s1[r] <= $signed(col_q[r]) * $signed(in_word.b[CellIdx]);
			end
		end
	end

	// add the products into the row sums
	always_ff @(posedge clk) begin
		if (s2_ready) begin
			w_s2.kind <= w_s1.kind;
			w_s2.col  <= w_s1.col;
			w_s2.b    <= w_s1.b;
			for (int r = 0; r < m4cm_pkg::NUM_ROWS; r++) begin
				w_s2.acc[r] <= w_s1.acc[r] +
					{{(m4cm_pkg::ACC_W - m4cm_pkg::PROD_W){prod_s1[r][m4cm_pkg::PROD_W-1]}},
					 prod_s1[r]};
			end
		end
	end

	assign out_valid = v_s2;
	assign out_word  = w_s2;

	// a load for this column updates the column at once
	a_load_stored: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && load_here |=> col_q == $past(in_word.b))
		else $error("column load not stored");

	// no load for this or an earlier column leaves the cell
	a_no_stale_load: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (w_s2.kind == m4cm_pkg::KIND_MUL) || (w_s2.col > MyCol))
		else $error("load passed its target cell");

endmodule

/* sv/m4cm_sat.sv */
// ----------------------------------------------------------------------------
// m4cm_sat
// Output register: shifts the exact row sums down, saturates to 32 bits and
// presents the product column.
// ----------------------------------------------------------------------------
module m4cm_sat #(
	parameter int FracBits = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  m4cm_pkg::word_t in_word,
	m4cm_rsp_if.source      rsp
);

	logic signed [m4cm_pkg::ACC_W-1:0]  shifted [m4cm_pkg::NUM_ROWS];
	logic [m4cm_pkg::ELEM_W-1:0]         clip    [m4cm_pkg::NUM_ROWS];
	logic [m4cm_pkg::NUM_ROWS-1:0]       over;
	logic                                valid_q;
	m4cm_pkg::col_t                      col_q;
	logic [m4cm_pkg::ELEM_W-1:0]         res_q   [m4cm_pkg::NUM_ROWS];
	logic                                sat_q;

	localparam int HiW = m4cm_pkg::ACC_W - m4cm_pkg::ELEM_W + 1;

	// floor shift, then clip each row to the 32-bit range
	always_comb begin
		for (int r = 0; r < m4cm_pkg::NUM_ROWS; r++) begin
			shifted[r] = $signed(in_word.acc[r]) >>> FracBits;
			over[r]    = !((&shifted[r][m4cm_pkg::ACC_W-1 -: HiW]) ||
			               !(|shifted[r][m4cm_pkg::ACC_W-1 -: HiW]));
			if (!over[r]) begin
				clip[r] = shifted[r][m4cm_pkg::ELEM_W-1:0];
			end else if (shifted[r][m4cm_pkg::ACC_W-1]) begin
				clip[r] = m4cm_pkg::SAT_MIN;
			end else begin
				clip[r] = m4cm_pkg::SAT_MAX;
			end
		end
	end

	assign in_ready = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// hold the result until the receiver takes it
	always_ff @(posedge clk) begin
		if (in_ready) begin
			col_q <= in_word.col;
			sat_q <= |over;
			for (int r = 0; r < m4cm_pkg::NUM_ROWS; r++) begin
				res_q[r] <= clip[r];
			end
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.result_column = col_q;
	assign rsp.res0          = res_q[0];
	assign rsp.res1          = res_q[1];
	assign rsp.res2          = res_q[2];
	assign rsp.res3          = res_q[3];
	assign rsp.saturated     = sat_q;

	// only multiply words reach the output
	a_only_mul: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> in_word.kind == m4cm_pkg::KIND_MUL)
		else $error("load word reached output stage");

	// a set flag means some row sits at a range limit
	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.saturated |->
			res_q[0] == m4cm_pkg::SAT_MAX || res_q[0] == m4cm_pkg::SAT_MIN ||
			res_q[1] == m4cm_pkg::SAT_MAX || res_q[1] == m4cm_pkg::SAT_MIN ||
			res_q[2] == m4cm_pkg::SAT_MAX || res_q[2] == m4cm_pkg::SAT_MIN ||
			res_q[3] == m4cm_pkg::SAT_MAX || res_q[3] == m4cm_pkg::SAT_MIN)
		else $error("saturation flag without clipped row");

endmodule
